// ===== hdl/gmds_pkg.sv =====
// shared types and constants for the grid maze depth-first solver
// no dependencies; compiled first
package gmds_pkg;

	localparam int COORD_W = 3;
	localparam int ADDR_W = 6;
	localparam int CELLS = 64;
	localparam int DEPTH_W = 7;
	localparam int SIDES_W = 4;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int GRID_COLS_DEF = 8;
	localparam int GRID_ROWS_DEF = 8;

	localparam logic [COORD_W-1:0] START_COL_RST = 3'd0;
	localparam logic [COORD_W-1:0] START_ROW_RST = 3'd0;
	localparam logic [COORD_W-1:0] GOAL_COL_RST = 3'd7;
	localparam logic [COORD_W-1:0] GOAL_ROW_RST = 3'd7;

	// search order, also the bit index in open_sides
	localparam logic [1:0] DIR_EAST = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_NORTH = 2'd2;
	localparam logic [1:0] DIR_WEST = 2'd3;

	typedef enum logic [1:0] {
		REG_START_COL = 2'd0,
		REG_START_ROW = 2'd1,
		REG_GOAL_COL  = 2'd2,
		REG_GOAL_ROW  = 2'd3
	} gmds_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] goal_col;
		logic [COORD_W-1:0] goal_row;
	} gmds_cfg_t;

	typedef struct packed {
		logic in_rdy;
		logic solve_clr;
		logic push_start;
		logic push_nb;
		logic dir_clr;
		logic dir_inc;
		logic pop;
		logic load_top;
		logic k_clr;
		logic emit_sel;
		logic out_path;
		logic out_fail;
	} gmds_cmd_t;

	typedef struct packed {
		logic solve_go;
		logic start_ok;
		logic at_goal;
		logic nb_ok;
		logic dir_last;
		logic stack_full;
		logic depth_one;
		logic k_last;
		logic out_free;
	} gmds_sts_t;

endpackage

// ===== hdl/gmds_cell_if.sv =====
// cell load channel: valid/ready handshake with one maze cell per word
// depends on gmds_pkg
interface gmds_cell_if;
	import gmds_pkg::*;
	logic valid;
	logic ready;
	logic [COORD_W-1:0] cell_col;
	logic [COORD_W-1:0] cell_row;
	logic [SIDES_W-1:0] open_sides;
	logic last_cell;

	modport source (output valid, output cell_col, output cell_row, output open_sides,
		output last_cell, input ready);
	modport sink (input valid, input cell_col, input cell_row, input open_sides,
		input last_cell, output ready);
endinterface

// ===== hdl/gmds_step_if.sv =====
// path step channel: valid/ready handshake with one path step per word
// depends on gmds_pkg
interface gmds_step_if;
	import gmds_pkg::*;
	logic valid;
	logic ready;
	logic [COORD_W-1:0] step_col;
	logic [COORD_W-1:0] step_row;
	logic found;
	logic last_step;

	modport source (output valid, output step_col, output step_row, output found,
		output last_step, input ready);
	modport sink (input valid, input step_col, input step_row, input found,
		input last_step, output ready);
endinterface

// ===== hdl/gmds_apb.sv =====
// apb register file holding start and goal coordinates
// depends on gmds_pkg
module gmds_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmds_pkg::PADDR_W-1:0] paddr,
	input  logic [gmds_pkg::PDATA_W-1:0] pwdata,
	output logic [gmds_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output gmds_pkg::gmds_cfg_t           cfg
);
	import gmds_pkg::*;

	gmds_cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;
	logic [COORD_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_col <= START_COL_RST;
			cfg_q.start_row <= START_ROW_RST;
			cfg_q.goal_col <= GOAL_COL_RST;
			cfg_q.goal_row <= GOAL_ROW_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_COL: cfg_q.start_col <= pwdata[COORD_W-1:0];
				REG_START_ROW: cfg_q.start_row <= pwdata[COORD_W-1:0];
				REG_GOAL_COL:  cfg_q.goal_col <= pwdata[COORD_W-1:0];
				REG_GOAL_ROW:  cfg_q.goal_row <= pwdata[COORD_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_COL: rd_val = cfg_q.start_col;
			REG_START_ROW: rd_val = cfg_q.start_row;
			REG_GOAL_COL:  rd_val = cfg_q.goal_col;
			REG_GOAL_ROW:  rd_val = cfg_q.goal_row;
		endcase
	end

	assign prdata = {{(PDATA_W-COORD_W){1'b0}}, rd_val};

endmodule

// ===== hdl/gmds_ctrl.sv =====
// search controller: sequences load, search steps, backtracking and path output
// depends on gmds_pkg; drives the datapath through gmds_cmd_t
module gmds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  gmds_pkg::gmds_sts_t sts,
	output gmds_pkg::gmds_cmd_t cmd
);
	import gmds_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_START   = 9'b000000010,
		S_CHECK   = 9'b000000100,
		S_TRY     = 9'b000001000,
		S_POP     = 9'b000010000,
		S_RELOAD  = 9'b000100000,
		S_EMIT_RD = 9'b001000000,
		S_EMIT_LD = 9'b010000000,
		S_FAIL    = 9'b100000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.solve_go) begin
					state_nxt = S_START;
				end
			end
			S_START: begin
				cmd.solve_clr = 1'b1;
				if (sts.start_ok) begin
					cmd.push_start = 1'b1;
					state_nxt = S_CHECK;
				end else begin
					state_nxt = S_FAIL;
				end
			end
			S_CHECK: begin
				if (sts.at_goal) begin
					cmd.k_clr = 1'b1;
					state_nxt = S_EMIT_RD;
				end else begin
					cmd.dir_clr = 1'b1;
					state_nxt = S_TRY;
				end
			end
			S_TRY: begin
				if (sts.nb_ok && !sts.stack_full) begin
					cmd.push_nb = 1'b1;
					state_nxt = S_CHECK;
				end else if (sts.nb_ok || sts.dir_last) begin
					state_nxt = S_POP;
				end else begin
					cmd.dir_inc = 1'b1;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_nxt = sts.depth_one ? S_FAIL : S_RELOAD;
			end
			S_RELOAD: begin
				cmd.load_top = 1'b1;
				state_nxt = S_CHECK;
			end
			S_EMIT_RD: begin
				cmd.emit_sel = 1'b1;
				state_nxt = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.emit_sel = 1'b1;
				if (sts.out_free) begin
					cmd.out_path = 1'b1;
					state_nxt = sts.k_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_FAIL: begin
				if (sts.out_free) begin
					cmd.out_fail = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/gmds_dp.sv =====
// search datapath: wall memory, coordinate stack, visited map, output register
// depends on gmds_pkg, gmds_cell_if, gmds_step_if
module gmds_dp #(
	parameter int GRID_COLS = gmds_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gmds_pkg::GRID_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gmds_pkg::gmds_cfg_t cfg,
	input  gmds_pkg::gmds_cmd_t cmd,
	output gmds_pkg::gmds_sts_t sts,
	gmds_cell_if.sink           load,
	gmds_step_if.source         step
);
	import gmds_pkg::*;

	logic [SIDES_W-1:0] wall_mem [CELLS];
	logic [ADDR_W-1:0] stk_mem [CELLS];

	logic [CELLS-1:0] visited_q;
	logic [ADDR_W-1:0] top_q;
	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] stk_rd_q;
	logic [SIDES_W-1:0] wall_rd_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [1:0] dir_q;

	logic [ADDR_W-1:0] stk_raddr;
	logic [ADDR_W-1:0] nb_addr;
	logic [ADDR_W-1:0] start_addr;
	logic [DEPTH_W-1:0] depth_m1;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic nb_inb;
	logic in_take;

	logic out_valid_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;
	logic out_found_q;
	logic out_last_q;

	assign load.ready = cmd.in_rdy;
	assign in_take = load.valid & load.ready;

	assign col = top_q[COORD_W-1:0];
	assign row = top_q[ADDR_W-1:COORD_W];
	assign start_addr = {cfg.start_row, cfg.start_col};
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign stk_raddr = cmd.emit_sel ? k_q : ADDR_W'(depth_q - DEPTH_W'(2));

	always_ff @(posedge clk) begin
		if (in_take) begin
			wall_mem[{load.cell_row, load.cell_col}] <= load.open_sides;
		end
		wall_rd_q <= wall_mem[top_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_start) begin
			stk_mem[ADDR_W'(0)] <= start_addr;
		end else if (cmd.push_nb) begin
			stk_mem[depth_q[ADDR_W-1:0]] <= nb_addr;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_comb begin
		unique case (dir_q)
			DIR_EAST: begin
				nb_inb = ({1'b0, col} + 4'd1) < 4'(GRID_COLS);
				nb_addr = {row, col + 3'd1};
			end
			DIR_SOUTH: begin
				nb_inb = ({1'b0, row} + 4'd1) < 4'(GRID_ROWS);
				nb_addr = {row + 3'd1, col};
			end
			DIR_NORTH: begin
				nb_inb = row != 3'd0;
				nb_addr = {row - 3'd1, col};
			end
			DIR_WEST: begin
				nb_inb = col != 3'd0;
				nb_addr = {row, col - 3'd1};
			end
		endcase
	end

	assign sts.solve_go = in_take & load.last_cell;
	assign sts.start_ok = ({1'b0, cfg.start_col} < 4'(GRID_COLS)) &&
		({1'b0, cfg.start_row} < 4'(GRID_ROWS));
	assign sts.at_goal = (col == cfg.goal_col) && (row == cfg.goal_row);
	assign sts.nb_ok = wall_rd_q[dir_q] & nb_inb & ~visited_q[nb_addr];
	assign sts.dir_last = dir_q == DIR_WEST;
	assign sts.stack_full = depth_q[DEPTH_W-1];
	assign sts.depth_one = depth_q == DEPTH_W'(1);
	assign sts.k_last = {1'b0, k_q} == depth_m1;
	assign sts.out_free = ~out_valid_q | step.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q <= '0;
			top_q <= '0;
			dir_q <= '0;
			k_q <= '0;
		end else begin
			// start push also clears the rest of the visited map
			if (cmd.push_start) begin
				visited_q <= {{(CELLS-1){1'b0}}, 1'b1} << start_addr;
				depth_q <= DEPTH_W'(1);
				top_q <= start_addr;
			end else if (cmd.solve_clr) begin
				visited_q <= '0;
				depth_q <= '0;
			end else if (cmd.push_nb) begin
				visited_q[nb_addr] <= 1'b1;
				depth_q <= depth_q + DEPTH_W'(1);
				top_q <= nb_addr;
			end else if (cmd.pop) begin
				depth_q <= depth_m1;
			end else if (cmd.load_top) begin
				top_q <= stk_rd_q;
			end
			if (cmd.dir_clr) begin
				dir_q <= DIR_EAST;
			end else if (cmd.dir_inc) begin
				dir_q <= dir_q + 2'd1;
			end
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.out_path) begin
				k_q <= k_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_path || cmd.out_fail) begin
			out_valid_q <= 1'b1;
		end else if (step.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_path) begin
			out_col_q <= stk_rd_q[COORD_W-1:0];
			out_row_q <= stk_rd_q[ADDR_W-1:COORD_W];
			out_found_q <= 1'b1;
			out_last_q <= sts.k_last;
		end else if (cmd.out_fail) begin
			out_col_q <= '0;
			out_row_q <= '0;
			out_found_q <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign step.valid = out_valid_q;
	assign step.step_col = out_col_q;
	assign step.step_row = out_row_q;
	assign step.found = out_found_q;
	assign step.last_step = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_nb |-> !sts.stack_full)
		else $error("push on full stack");

	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_nb |=> visited_q[top_q])
		else $error("pushed cell not marked visited");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop on empty stack");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_path || cmd.out_fail) |-> (!out_valid_q || step.ready))
		else $error("output word overwritten while stalled");

endmodule

// ===== hdl/grid_maze_depth_first_solver_top.sv =====
// top level of the grid maze depth-first solver
// depends on gmds_pkg, gmds_cell_if, gmds_step_if, gmds_apb, gmds_ctrl, gmds_dp
//
// The maze is loaded on the load channel, one word per cell with its open
// sides. A word with last_cell set stores that cell and starts the solve;
// the load channel takes a word every cycle while the block is idle and
// none while a solve runs. Start and goal come from four apb registers.
// Each search step passes a check state and then a try state that tests the
// directions in order (east, south, north, west); a backtrack passes a pop
// and a reload state, as the stack memory has a single registered read port.
// The visited map is cleared at solve start, so there is no clearing pass.
// The path leaves on the step channel bottom to top, last_step on the
// final word, each read then loaded; with no path one word with found clear.
// A stalled step channel holds the output register and the sequencer waits;
// the next load is taken as soon as the final word sits in that register.
// Reset returns the sequencer to idle, empties the stack and visited map
// and loads the default start and goal.
module grid_maze_depth_first_solver_top #(
	parameter int GRID_COLS = gmds_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = gmds_pkg::GRID_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gmds_cell_if.sink                     load,
	gmds_step_if.source                   step,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmds_pkg::PADDR_W-1:0] paddr,
	input  logic [gmds_pkg::PDATA_W-1:0] pwdata,
	output logic [gmds_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);
	import gmds_pkg::*;

	gmds_cfg_t cfg;
	gmds_cmd_t cmd;
	gmds_sts_t sts;

	gmds_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gmds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	gmds_dp #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.load   (load),
		.step   (step)
	);

endmodule
